/* design/vrt_pkg.sv */
package vrt_pkg;

  localparam int CELL_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int DIST_BITS = 32;

  localparam int ORG_W   = 40;
  localparam int DIR_W   = 16;
  localparam int LIM_W   = 16;
  localparam int CLS_W   = 2;
  localparam int WH_W    = 13;
  localparam int STEPS_W = 10;
  localparam int KIND_W  = 2;
  localparam int FACE_W  = 3;
  localparam int IN_W    = 192;

  localparam logic [WH_W-1:0] WH_RESET = 13'd256;

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_ANSWER = 1'b1;

  localparam logic [CLS_W-1:0] CLS_PASS  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SOLID = 2'd1;

  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HIT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MISS  = 2'd2;

  localparam logic [1:0] SG_NONE = 2'd0;
  localparam logic [1:0] SG_POS  = 2'd1;
  localparam logic [1:0] SG_NEG  = 2'd2;

  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_MINIT,
    ST_MUL,
    ST_AXIS,
    ST_WALK,
    ST_HIT,
    ST_MISS
  } state_e;

  typedef struct packed {
    logic load_in;
    logic len_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic mul_start;
    logic mul_step;
    logic axis_store;
    logic walk_step;
    logic emit_hit;
    logic emit_miss;
  } cmd_t;

  typedef struct packed {
    logic             in_func;
    logic             in_bad;
    logic [CLS_W-1:0] in_cls;
    logic             iter_last;
    logic             last_axis;
    logic             out_free;
    logic             walk_res;
    logic             walk_query;
  } sts_t;

endpackage

/* design/voxel_ray_traversal_unit.sv */
// Walks a ray through a 3D cell grid. A start word (tuser 0) carries origin, direction
// and distance limit; setup then runs a bit-serial square root, one shared restoring
// divider of 40 steps and a shift-add multiplier of FracBits + 1 steps per axis; a zero
// direction or limit gives a miss word instead. Afterwards the walker advances one cell
// per cycle while the result register is free, skipping cells outside the vertical
// range, until it sends a query or miss word. A passable answer word (tuser 1) resumes
// the walk, a solid one gives a hit word, any other a miss. One item is processed
// at a time; the result register lets a new item be taken while the last result waits.
module voxel_ray_traversal_unit #(
  parameter int CellBits = vrt_pkg::CELL_BITS,
  parameter int FracBits = vrt_pkg::FRAC_BITS,
  parameter int DistBits = vrt_pkg::DIST_BITS,
  localparam int OutW    = ((3 * CellBits + vrt_pkg::FACE_W + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vrt_pkg::WH_W-1:0]   cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, cell_class
  input  logic [vrt_pkg::IN_W-1:0]   s_axis_tdata,
  // func
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // cell_x, cell_y, cell_z, face
  output logic [OutW-1:0]            m_axis_tdata,
  // kind
  output logic [vrt_pkg::KIND_W-1:0] m_axis_tuser
);

  vrt_pkg::cmd_t cmd;
  vrt_pkg::sts_t sts;

  vrt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  vrt_datapath #(
    .CellBits (CellBits),
    .FracBits (FracBits),
    .DistBits (DistBits)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

endmodule

/* design/vrt_ctrl.sv */
module vrt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  vrt_pkg::sts_t sts_i,
  output vrt_pkg::cmd_t cmd_o
);

  vrt_pkg::state_e state_q, state_d;
  logic            active_q, active_d;
  logic            fire;

  assign fire = s_axis_tvalid_i && (state_q == vrt_pkg::ST_IDLE);

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    case (state_q)
      vrt_pkg::ST_IDLE: begin
        if (fire) begin
          if (sts_i.in_func == vrt_pkg::FUNC_START) begin
            active_d = 1'b0;
            state_d  = sts_i.in_bad ? vrt_pkg::ST_MISS : vrt_pkg::ST_LEN;
          end else if (active_q) begin
            if (sts_i.in_cls == vrt_pkg::CLS_PASS) begin
              state_d = vrt_pkg::ST_WALK;
            end else if (sts_i.in_cls == vrt_pkg::CLS_SOLID) begin
              state_d = vrt_pkg::ST_HIT;
            end else begin
              state_d = vrt_pkg::ST_MISS;
            end
          end
        end
      end
      vrt_pkg::ST_LEN:   state_d = vrt_pkg::ST_SQRT;
      vrt_pkg::ST_SQRT: begin
        if (sts_i.iter_last) begin
          state_d = vrt_pkg::ST_DINIT;
        end
      end
      vrt_pkg::ST_DINIT: state_d = vrt_pkg::ST_DIV;
      vrt_pkg::ST_DIV: begin
        if (sts_i.iter_last) begin
          state_d = vrt_pkg::ST_MINIT;
        end
      end
      vrt_pkg::ST_MINIT: state_d = vrt_pkg::ST_MUL;
      vrt_pkg::ST_MUL: begin
        if (sts_i.iter_last) begin
          state_d = vrt_pkg::ST_AXIS;
        end
      end
      vrt_pkg::ST_AXIS: begin
        if (sts_i.last_axis) begin
          active_d = 1'b1;
          state_d  = vrt_pkg::ST_WALK;
        end else begin
          state_d = vrt_pkg::ST_DINIT;
        end
      end
      vrt_pkg::ST_WALK: begin
        if (sts_i.out_free && sts_i.walk_res) begin
          active_d = sts_i.walk_query;
          state_d  = vrt_pkg::ST_IDLE;
        end
      end
      vrt_pkg::ST_HIT, vrt_pkg::ST_MISS: begin
        if (sts_i.out_free) begin
          active_d = 1'b0;
          state_d  = vrt_pkg::ST_IDLE;
        end
      end
      default: state_d = vrt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      vrt_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load_in   = fire;
      end
      vrt_pkg::ST_LEN:   cmd_o.len_start  = 1'b1;
      vrt_pkg::ST_SQRT:  cmd_o.sqrt_step  = 1'b1;
      vrt_pkg::ST_DINIT: cmd_o.div_start  = 1'b1;
      vrt_pkg::ST_DIV:   cmd_o.div_step   = 1'b1;
      vrt_pkg::ST_MINIT: cmd_o.mul_start  = 1'b1;
      vrt_pkg::ST_MUL:   cmd_o.mul_step   = 1'b1;
      vrt_pkg::ST_AXIS:  cmd_o.axis_store = 1'b1;
      vrt_pkg::ST_WALK:  cmd_o.walk_step  = sts_i.out_free;
      vrt_pkg::ST_HIT:   cmd_o.emit_hit   = sts_i.out_free;
      vrt_pkg::ST_MISS:  cmd_o.emit_miss  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vrt_pkg::ST_IDLE;
      active_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
    end
  end

endmodule

/* design/vrt_datapath.sv */
module vrt_datapath #(
  parameter int CellBits = vrt_pkg::CELL_BITS,
  parameter int FracBits = vrt_pkg::FRAC_BITS,
  parameter int DistBits = vrt_pkg::DIST_BITS,
  localparam int OutW    = ((3 * CellBits + vrt_pkg::FACE_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vrt_pkg::WH_W-1:0]    cfg_wdata_i,
  input  logic [vrt_pkg::IN_W-1:0]    s_axis_tdata_i,
  input  logic                        s_axis_tuser_i,
  input  vrt_pkg::cmd_t               cmd_i,
  output vrt_pkg::sts_t               sts_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [OutW-1:0]             m_axis_tdata_o,
  output logic [vrt_pkg::KIND_W-1:0]  m_axis_tuser_o
);

  localparam int OW   = vrt_pkg::ORG_W;
  localparam int LW   = 40;
  localparam int CNTW = $clog2(LW);
  localparam int AW   = FracBits + 1 + DistBits;
  localparam int CW   = DistBits + FracBits + 8;
  localparam int EW   = OW + CellBits;
  localparam int YW   = CellBits + vrt_pkg::WH_W;

  logic [vrt_pkg::WH_W-1:0] wh_q;

  logic [OW-1:0]        ox_q, oy_q, oz_q;
  logic signed [15:0]   dx_q, dy_q, dz_q;

  logic [63:0]          rad_q;
  logic [35:0]          rem_q;
  logic [31:0]          root_q;
  logic [CNTW-1:0]      cnt_q;
  logic [1:0]           axis_q;

  logic [LW-1:0]        num_q;
  logic [16:0]          drem_q, dvs_q;
  logic [FracBits:0]    part_q;
  logic [AW-1:0]        acc_q;
  logic [DistBits-1:0]  stp_q;

  logic [CellBits-1:0]  cx_q, cy_q, cz_q;
  logic [DistBits-1:0]  nx_q, ny_q, nz_q, sx_q, sy_q, sz_q;
  logic [5:0]           sg_q;
  logic [vrt_pkg::STEPS_W-1:0] steps_q;
  logic [vrt_pkg::LIM_W-1:0]   lim_q;
  logic [vrt_pkg::FACE_W-1:0]  face_q;

  logic                       ovalid_q;
  logic [vrt_pkg::KIND_W-1:0] okind_q;
  logic [CellBits-1:0]        ocx_q, ocy_q, ocz_q;
  logic [vrt_pkg::FACE_W-1:0] oface_q;

  logic [OW-1:0]           in_ox, in_oy, in_oz;
  logic [15:0]             in_dx, in_dy, in_dz, in_md;
  logic [vrt_pkg::CLS_W-1:0] in_cls;

  assign in_ox  = s_axis_tdata_i[39:0];
  assign in_oy  = s_axis_tdata_i[79:40];
  assign in_oz  = s_axis_tdata_i[119:80];
  assign in_dx  = s_axis_tdata_i[135:120];
  assign in_dy  = s_axis_tdata_i[151:136];
  assign in_dz  = s_axis_tdata_i[167:152];
  assign in_md  = s_axis_tdata_i[183:168];
  assign in_cls = s_axis_tdata_i[185:184];

  function automatic logic [CellBits-1:0] org_cell(input logic [OW-1:0] o);
    logic signed [EW-1:0] e;
    e = EW'(signed'(o));
    e = e >>> FracBits;
    return e[CellBits-1:0];
  endfunction

  function automatic logic [CellBits-1:0] move(input logic [CellBits-1:0] c,
                                               input logic [1:0] sg);
    logic [CellBits-1:0] r;
    r = c;
    if (sg == vrt_pkg::SG_POS) begin
      r = c + CellBits'(1);
    end else if (sg == vrt_pkg::SG_NEG) begin
      r = c - CellBits'(1);
    end
    return r;
  endfunction

  function automatic logic [DistBits-1:0] sadd(input logic [DistBits-1:0] a,
                                               input logic [DistBits-1:0] b);
    logic [DistBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DistBits] ? '1 : s[DistBits-1:0];
  endfunction

  // Square root of len2 * 2^32, two radicand bits per step.
  logic [35:0] sq_rem_n, sq_trial;
  logic [31:0] len2;
  logic [LW-1:0] lenn;
  logic [47:0] lenn_w;

  assign len2 = 32'(32'(dx_q) * 32'(dx_q)) + 32'(32'(dy_q) * 32'(dy_q)) +
                32'(32'(dz_q) * 32'(dz_q));
  assign sq_rem_n = {rem_q[33:0], rad_q[63:62]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign lenn_w   = {root_q, 16'h0000} >> (32 - FracBits);
  assign lenn     = lenn_w[LW-1:0];

  logic signed [15:0] ad_s;
  logic [OW-1:0]      ao;
  logic [16:0]        ad_abs;
  logic [17:0]        dv_t;
  logic               dv_ge;
  logic [FracBits-1:0] fr;
  logic               d_zero, d_pos;

  always_comb begin
    case (axis_q)
      vrt_pkg::AXIS_X: begin ad_s = dx_q; ao = ox_q; end
      vrt_pkg::AXIS_Y: begin ad_s = dy_q; ao = oy_q; end
      default:         begin ad_s = dz_q; ao = oz_q; end
    endcase
  end

  assign d_zero = (ad_s == 16'sd0);
  assign d_pos  = !ad_s[15] && !d_zero;
  assign ad_abs = ad_s[15] ? (17'd0 - {1'b1, ad_s}) : {1'b0, ad_s};
  assign fr     = ao[FracBits-1:0];
  assign dv_t   = {drem_q, num_q[LW-1]};
  assign dv_ge  = dv_t >= {1'b0, dvs_q};

  logic [LW+DistBits-1:0] q_ext;
  logic [DistBits-1:0]    q_sat;
  logic [DistBits:0]      mres;
  logic [DistBits-1:0]    mres_sat;

  assign q_ext    = (LW + DistBits)'(num_q);
  assign q_sat    = (|(q_ext >> DistBits)) ? '1 : q_ext[DistBits-1:0];
  assign mres     = acc_q[AW-1:FracBits];
  assign mres_sat = mres[DistBits] ? '1 : mres[DistBits-1:0];

  // One cell step of the walk.
  logic                       w_res, w_query, w_pick_x, w_pick_y;
  logic [1:0]                 w_sg;
  logic [DistBits-1:0]        w_t;
  logic [vrt_pkg::FACE_W-1:0] w_face;
  logic [CellBits-1:0]        w_cx, w_cy, w_cz;
  logic [DistBits-1:0]        w_nx, w_ny, w_nz;
  logic [CW-1:0]              w_lim;
  logic                       w_yin;

  assign w_pick_x = (nx_q <= ny_q) && (nx_q <= nz_q);
  assign w_pick_y = !w_pick_x && (ny_q <= nz_q);
  assign w_lim    = CW'(lim_q) << (FracBits - 8);

  always_comb begin
    w_cx = cx_q; w_cy = cy_q; w_cz = cz_q;
    w_nx = nx_q; w_ny = ny_q; w_nz = nz_q;
    if (w_pick_x) begin
      w_sg   = sg_q[1:0];
      w_t    = nx_q;
      w_cx   = move(cx_q, w_sg);
      w_nx   = sadd(nx_q, sx_q);
      w_face = (w_sg == vrt_pkg::SG_POS) ? vrt_pkg::FACE_NEG_X : vrt_pkg::FACE_POS_X;
    end else if (w_pick_y) begin
      w_sg   = sg_q[3:2];
      w_t    = ny_q;
      w_cy   = move(cy_q, w_sg);
      w_ny   = sadd(ny_q, sy_q);
      w_face = (w_sg == vrt_pkg::SG_POS) ? vrt_pkg::FACE_NEG_Y : vrt_pkg::FACE_POS_Y;
    end else begin
      w_sg   = sg_q[5:4];
      w_t    = nz_q;
      w_cz   = move(cz_q, w_sg);
      w_nz   = sadd(nz_q, sz_q);
      w_face = (w_sg == vrt_pkg::SG_POS) ? vrt_pkg::FACE_NEG_Z : vrt_pkg::FACE_POS_Z;
    end
    w_yin   = !w_cy[CellBits-1] && (YW'(w_cy) < YW'(wh_q));
    w_query = 1'b0;
    w_res   = 1'b0;
    if (steps_q == '0) begin
      w_res = 1'b1;
    end else if (CW'(w_t) > w_lim) begin
      w_res = 1'b1;
    end else if (w_yin) begin
      w_res   = 1'b1;
      w_query = 1'b1;
    end
  end

  logic [1:0] sg_new;
  assign sg_new = d_zero ? vrt_pkg::SG_NONE : (d_pos ? vrt_pkg::SG_POS : vrt_pkg::SG_NEG);

  logic emit_any;
  assign emit_any = (cmd_i.walk_step && w_res) || cmd_i.emit_hit || cmd_i.emit_miss;

  always_comb begin
    sts_o            = '0;
    sts_o.in_func    = s_axis_tuser_i;
    sts_o.in_bad     = ((in_dx == '0) && (in_dy == '0) && (in_dz == '0)) || (in_md == '0);
    sts_o.in_cls     = in_cls;
    sts_o.iter_last  = (cnt_q == '0);
    sts_o.last_axis  = (axis_q == vrt_pkg::AXIS_Z);
    sts_o.out_free   = !ovalid_q || m_axis_tready_i;
    sts_o.walk_res   = w_res;
    sts_o.walk_query = w_query;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wh_q     <= vrt_pkg::WH_RESET;
      ovalid_q <= 1'b0;
      okind_q  <= '0;
      ocx_q <= '0; ocy_q <= '0; ocz_q <= '0; oface_q <= '0;
      cx_q <= '0; cy_q <= '0; cz_q <= '0;
      nx_q <= '0; ny_q <= '0; nz_q <= '0;
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
      sg_q <= '0; steps_q <= '0; lim_q <= '0; face_q <= '0;
    end else begin
      if (cfg_we_i) begin
        wh_q <= cfg_wdata_i;
      end
      if (emit_any) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.load_in && (s_axis_tuser_i == vrt_pkg::FUNC_START)) begin
        cx_q    <= org_cell(in_ox);
        cy_q    <= org_cell(in_oy);
        cz_q    <= org_cell(in_oz);
        lim_q   <= in_md;
        steps_q <= vrt_pkg::STEPS_W'((18'(in_md) * 18'd3) >> 8) + vrt_pkg::STEPS_W'(4);
        face_q  <= '0;
      end
      if (cmd_i.axis_store) begin
        case (axis_q)
          vrt_pkg::AXIS_X: begin
            sx_q <= d_zero ? '1 : stp_q;
            nx_q <= d_zero ? '1 : mres_sat;
            sg_q[1:0] <= sg_new;
          end
          vrt_pkg::AXIS_Y: begin
            sy_q <= d_zero ? '1 : stp_q;
            ny_q <= d_zero ? '1 : mres_sat;
            sg_q[3:2] <= sg_new;
          end
          default: begin
            sz_q <= d_zero ? '1 : stp_q;
            nz_q <= d_zero ? '1 : mres_sat;
            sg_q[5:4] <= sg_new;
          end
        endcase
      end
      if (cmd_i.walk_step && (steps_q != '0)) begin
        steps_q <= steps_q - vrt_pkg::STEPS_W'(1);
        cx_q <= w_cx; cy_q <= w_cy; cz_q <= w_cz;
        nx_q <= w_nx; ny_q <= w_ny; nz_q <= w_nz;
        if (w_query) begin
          face_q <= w_face;
        end
      end
      if (cmd_i.walk_step && w_res) begin
        okind_q  <= w_query ? vrt_pkg::KIND_QUERY : vrt_pkg::KIND_MISS;
        ocx_q    <= w_query ? w_cx : '0;
        ocy_q    <= w_query ? w_cy : '0;
        ocz_q    <= w_query ? w_cz : '0;
        oface_q  <= w_query ? w_face : '0;
      end
      if (cmd_i.emit_hit) begin
        okind_q  <= vrt_pkg::KIND_HIT;
        ocx_q    <= cx_q;
        ocy_q    <= cy_q;
        ocz_q    <= cz_q;
        oface_q  <= face_q;
      end
      if (cmd_i.emit_miss) begin
        okind_q  <= vrt_pkg::KIND_MISS;
        ocx_q    <= '0;
        ocy_q    <= '0;
        ocz_q    <= '0;
        oface_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ox_q <= in_ox; oy_q <= in_oy; oz_q <= in_oz;
      dx_q <= in_dx; dy_q <= in_dy; dz_q <= in_dz;
    end
    if (cmd_i.len_start) begin
      rad_q  <= {len2, 32'h0};
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CNTW'(31);
      axis_q <= vrt_pkg::AXIS_X;
    end
    if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[61:0], 2'b00};
      cnt_q <= cnt_q - CNTW'(1);
      if (sq_rem_n >= sq_trial) begin
        rem_q  <= sq_rem_n - sq_trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= sq_rem_n;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    if (cmd_i.div_start) begin
      num_q  <= lenn;
      drem_q <= '0;
      dvs_q  <= ad_abs;
      cnt_q  <= CNTW'(LW - 1);
    end
    if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (dv_ge) begin
        drem_q <= 17'(dv_t - {1'b0, dvs_q});
        num_q  <= {num_q[LW-2:0], 1'b1};
      end else begin
        drem_q <= dv_t[16:0];
        num_q  <= {num_q[LW-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_start) begin
      stp_q  <= q_sat;
      part_q <= d_pos ? ((FracBits + 1)'(1) << FracBits) - (FracBits + 1)'(fr)
                      : (FracBits + 1)'(fr);
      acc_q  <= '0;
      cnt_q  <= CNTW'(FracBits);
    end
    if (cmd_i.mul_step) begin
      cnt_q  <= cnt_q - CNTW'(1);
      part_q <= {part_q[FracBits-1:0], 1'b0};
      acc_q  <= {acc_q[AW-2:0], 1'b0} + (part_q[FracBits] ? AW'(stp_q) : AW'(0));
    end
    if (cmd_i.axis_store) begin
      axis_q <= axis_q + 2'd1;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tdata_o  = OutW'({oface_q, ocz_q, ocy_q, ocx_q});

endmodule

/* tb/voxel_ray_traversal_unit_test.sv */
`timescale 1ns / 1ps

module voxel_ray_traversal_unit_test;

  localparam int OutW = ((3 * vrt_pkg::CELL_BITS + vrt_pkg::FACE_W + 7) / 8) * 8;
  localparam int SettleCycles = 400;
  localparam int WatchLimit = 6000;
  localparam int HoldCycles = 600;

  typedef struct packed {
    logic                          func;
    logic [vrt_pkg::ORG_W-1:0]     org_x;
    logic [vrt_pkg::ORG_W-1:0]     org_y;
    logic [vrt_pkg::ORG_W-1:0]     org_z;
    logic [vrt_pkg::DIR_W-1:0]     dir_x;
    logic [vrt_pkg::DIR_W-1:0]     dir_y;
    logic [vrt_pkg::DIR_W-1:0]     dir_z;
    logic [vrt_pkg::LIM_W-1:0]     limit;
    logic [vrt_pkg::CLS_W-1:0]     cls;
  } ray_word_t;

  typedef struct packed {
    logic [vrt_pkg::KIND_W-1:0]    kind;
    logic [vrt_pkg::CELL_BITS-1:0] cx;
    logic [vrt_pkg::CELL_BITS-1:0] cy;
    logic [vrt_pkg::CELL_BITS-1:0] cz;
    logic [vrt_pkg::FACE_W-1:0]    face;
  } cell_word_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [vrt_pkg::WH_W-1:0]     cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [vrt_pkg::IN_W-1:0]     s_axis_tdata = '0;
  logic                         s_axis_tuser = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [OutW-1:0]              m_axis_tdata;
  logic [vrt_pkg::KIND_W-1:0]   m_axis_tuser;

  voxel_ray_traversal_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ray_word_t  rays_pending[$];
  cell_word_t cells_due[$];
  ray_word_t  word_on_bus;
  int         words_in = 0;
  int         words_out = 0;
  int         errors = 0;
  int         hits_seen = 0;
  int         misses_seen = 0;
  int         queries_seen = 0;
  int         heights_used = 0;
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;
  bit         hold_taken = 1'b0;

  // Mirror of the traversal state.
  logic [vrt_pkg::WH_W-1:0]      height;
  logic                          active;
  logic [vrt_pkg::CELL_BITS-1:0] cell_x, cell_y, cell_z;
  logic [vrt_pkg::DIST_BITS-1:0] next_x, next_y, next_z;
  logic [vrt_pkg::DIST_BITS-1:0] step_x, step_y, step_z;
  logic [1:0]                    sg_x, sg_y, sg_z;
  logic [vrt_pkg::STEPS_W-1:0]   budget;
  logic [vrt_pkg::LIM_W-1:0]     limit_held;
  logic [vrt_pkg::FACE_W-1:0]    face_held;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [vrt_pkg::DIST_BITS-1:0] dist_add(
      logic [vrt_pkg::DIST_BITS-1:0] a, logic [vrt_pkg::DIST_BITS-1:0] b);
    logic [vrt_pkg::DIST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[vrt_pkg::DIST_BITS] ? '1 : s[vrt_pkg::DIST_BITS-1:0];
  endfunction

  function automatic logic [vrt_pkg::DIST_BITS-1:0] frac_scale(
      logic [63:0] a, logic [vrt_pkg::DIST_BITS-1:0] b);
    logic [63:0] hi, r, maxd;
    maxd = (64'd1 << vrt_pkg::DIST_BITS) - 1;
    hi = a * (64'(b) >> 24);
    if (hi > (maxd >> (24 - vrt_pkg::FRAC_BITS))) return '1;
    r = (hi << (24 - vrt_pkg::FRAC_BITS)) +
        ((a * (64'(b) & 64'hFFFFFF)) >> vrt_pkg::FRAC_BITS);
    return r > maxd ? '1 : r[vrt_pkg::DIST_BITS-1:0];
  endfunction

  task automatic setup_axis(input logic [vrt_pkg::ORG_W-1:0] o,
                            input logic [vrt_pkg::DIR_W-1:0] d,
                            input logic [63:0] lenn,
                            output logic [vrt_pkg::DIST_BITS-1:0] stp,
                            output logic [vrt_pkg::DIST_BITS-1:0] nxt,
                            output logic [1:0] sg);
    logic [63:0] fr, ad, q;
    fr = 64'(o[vrt_pkg::FRAC_BITS-1:0]);
    if (d == 0) begin
      stp = '1;
      nxt = '1;
      sg = vrt_pkg::SG_NONE;
    end else begin
      ad = d[vrt_pkg::DIR_W-1] ? 64'(-longint'($signed(d))) : 64'(d);
      q = lenn / ad;
      stp = q > ((64'd1 << vrt_pkg::DIST_BITS) - 1) ? '1 : q[vrt_pkg::DIST_BITS-1:0];
      if (!d[vrt_pkg::DIR_W-1]) begin
        sg = vrt_pkg::SG_POS;
        nxt = frac_scale((64'd1 << vrt_pkg::FRAC_BITS) - fr, stp);
      end else begin
        sg = vrt_pkg::SG_NEG;
        nxt = frac_scale(fr, stp);
      end
    end
  endtask

  function automatic logic [vrt_pkg::CELL_BITS-1:0] move_cell(
      logic [vrt_pkg::CELL_BITS-1:0] c, logic [1:0] sg);
    if (sg == vrt_pkg::SG_POS) return c + 1'b1;
    if (sg == vrt_pkg::SG_NEG) return c - 1'b1;
    return c;
  endfunction

  task automatic walk_ray(output cell_word_t r);
    logic [vrt_pkg::DIST_BITS-1:0] t;
    logic [vrt_pkg::FACE_W-1:0]    f;
    logic [63:0]                   lim;
    longint                        ys;
    lim = 64'(limit_held) << (vrt_pkg::FRAC_BITS - 8);
    while (budget > 0) begin
      budget = budget - 1'b1;
      if (next_x <= next_y && next_x <= next_z) begin
        t = next_x;
        cell_x = move_cell(cell_x, sg_x);
        next_x = dist_add(next_x, step_x);
        f = sg_x == vrt_pkg::SG_POS ? vrt_pkg::FACE_NEG_X : vrt_pkg::FACE_POS_X;
      end else if (next_y <= next_z) begin
        t = next_y;
        cell_y = move_cell(cell_y, sg_y);
        next_y = dist_add(next_y, step_y);
        f = sg_y == vrt_pkg::SG_POS ? vrt_pkg::FACE_NEG_Y : vrt_pkg::FACE_POS_Y;
      end else begin
        t = next_z;
        cell_z = move_cell(cell_z, sg_z);
        next_z = dist_add(next_z, step_z);
        f = sg_z == vrt_pkg::SG_POS ? vrt_pkg::FACE_NEG_Z : vrt_pkg::FACE_POS_Z;
      end
      if (64'(t) > lim) break;
      ys = longint'($signed(cell_y));
      if (ys < 0 || ys >= longint'(height)) continue;
      face_held = f;
      r = '{vrt_pkg::KIND_QUERY, cell_x, cell_y, cell_z, f};
      return;
    end
    active = 1'b0;
    r = '{vrt_pkg::KIND_MISS, '0, '0, '0, '0};
  endtask

  task automatic trace_predict(input ray_word_t w);
    cell_word_t  r;
    logic [63:0] len2, lenn;
    longint      dx, dy, dz;
    if (w.func == vrt_pkg::FUNC_START) begin
      active = 1'b0;
      if ((w.dir_x == 0 && w.dir_y == 0 && w.dir_z == 0) || w.limit == 0) begin
        cells_due.push_back('{vrt_pkg::KIND_MISS, '0, '0, '0, '0});
        return;
      end
      dx = longint'($signed(w.dir_x));
      dy = longint'($signed(w.dir_y));
      dz = longint'($signed(w.dir_z));
      len2 = 64'(dx * dx + dy * dy + dz * dz);
      lenn = (root64(len2 << 32) << 8) >> (24 - vrt_pkg::FRAC_BITS);
      setup_axis(w.org_x, w.dir_x, lenn, step_x, next_x, sg_x);
      setup_axis(w.org_y, w.dir_y, lenn, step_y, next_y, sg_y);
      setup_axis(w.org_z, w.dir_z, lenn, step_z, next_z, sg_z);
      cell_x = w.org_x[vrt_pkg::ORG_W-1:vrt_pkg::FRAC_BITS];
      cell_y = w.org_y[vrt_pkg::ORG_W-1:vrt_pkg::FRAC_BITS];
      cell_z = w.org_z[vrt_pkg::ORG_W-1:vrt_pkg::FRAC_BITS];
      limit_held = w.limit;
      budget = vrt_pkg::STEPS_W'(((32'(w.limit) * 3) >> 8) + 4);
      face_held = '0;
      active = 1'b1;
      walk_ray(r);
      cells_due.push_back(r);
    end else if (active) begin
      if (w.cls == vrt_pkg::CLS_PASS) begin
        walk_ray(r);
        cells_due.push_back(r);
      end else if (w.cls == vrt_pkg::CLS_SOLID) begin
        active = 1'b0;
        cells_due.push_back('{vrt_pkg::KIND_HIT, cell_x, cell_y, cell_z, face_held});
      end else begin
        active = 1'b0;
        cells_due.push_back('{vrt_pkg::KIND_MISS, '0, '0, '0, '0});
      end
    end
  endtask

  // Sender side.
  int sender_gap = 0;
  int sender_seen = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(s_axis_tvalid && words_in == sender_seen)) begin
        if (sender_gap > 0) begin
          sender_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (rays_pending.size() > 0) begin
          word_on_bus = rays_pending.pop_front();
          s_axis_tdata <= {6'b0, word_on_bus.cls, word_on_bus.limit, word_on_bus.dir_z,
                           word_on_bus.dir_y, word_on_bus.dir_x, word_on_bus.org_z,
                           word_on_bus.org_y, word_on_bus.org_x};
          s_axis_tuser <= word_on_bus.func;
          s_axis_tvalid <= 1'b1;
          sender_gap = idle_on ? $urandom_range(0, 15) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      sender_seen = words_in;
    end
  end

  // Receiver side.
  int recv_wait = 0;
  int recv_seen = 0;
  int hold_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (words_out != recv_seen) recv_wait = idle_on ? $urandom_range(0, 15) : 0;
      recv_seen = words_out;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor, checker and watchdog.
  cell_word_t got, want;
  int quiet = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        trace_predict(word_on_bus);
        words_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        got = '{m_axis_tuser, m_axis_tdata[vrt_pkg::CELL_BITS-1:0],
                m_axis_tdata[2*vrt_pkg::CELL_BITS-1:vrt_pkg::CELL_BITS],
                m_axis_tdata[3*vrt_pkg::CELL_BITS-1:2*vrt_pkg::CELL_BITS],
                m_axis_tdata[3*vrt_pkg::CELL_BITS+vrt_pkg::FACE_W-1:3*vrt_pkg::CELL_BITS]};
        if (cells_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word kind=%0d cell=%h,%h,%h face=%0d", $time,
                   got.kind, got.cx, got.cy, got.cz, got.face);
        end else begin
          want = cells_due.pop_front();
          if (got != want) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d cell=%h,%h,%h face=%0d", $time,
                     want.kind, want.cx, want.cy, want.cz, want.face);
            $display("%0t:          actual   kind=%0d cell=%h,%h,%h face=%0d", $time,
                     got.kind, got.cx, got.cy, got.cz, got.face);
          end
          if (want.kind == vrt_pkg::KIND_HIT) hits_seen++;
          else if (want.kind == vrt_pkg::KIND_MISS) misses_seen++;
          else queries_seen++;
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (rays_pending.size() == 0 && !s_axis_tvalid && cells_due.size() == 0)) begin
        quiet = 0;
      end else if (++quiet >= WatchLimit) begin
        $display("watchdog expired with %0d words outstanding", cells_due.size());
        $display("voxel_ray_traversal_unit_test failed");
        $finish;
      end
    end
  end

  function automatic ray_word_t start_word(
      logic [vrt_pkg::ORG_W-1:0] ox, logic [vrt_pkg::ORG_W-1:0] oy,
      logic [vrt_pkg::ORG_W-1:0] oz, logic [vrt_pkg::DIR_W-1:0] dx,
      logic [vrt_pkg::DIR_W-1:0] dy, logic [vrt_pkg::DIR_W-1:0] dz,
      logic [vrt_pkg::LIM_W-1:0] lim);
    return '{vrt_pkg::FUNC_START, ox, oy, oz, dx, dy, dz, lim, 2'($urandom)};
  endfunction

  function automatic ray_word_t answer_word(logic [vrt_pkg::CLS_W-1:0] c);
    ray_word_t w;
    w = '{vrt_pkg::FUNC_ANSWER, 40'({$urandom, $urandom}), 40'({$urandom, $urandom}),
          40'({$urandom, $urandom}), 16'($urandom), 16'($urandom), 16'($urandom),
          16'($urandom), c};
    return w;
  endfunction

  function automatic logic [vrt_pkg::ORG_W-1:0] near_origin(int lo, int hi);
    return vrt_pkg::ORG_W'((longint'(lo + int'($urandom_range(0, hi - lo)))
                            << vrt_pkg::FRAC_BITS) | longint'($urandom_range(0, 65535)));
  endfunction

  function automatic logic [vrt_pkg::DIR_W-1:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_height(logic [vrt_pkg::WH_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    height = v;
    heights_used++;
  endtask

  task automatic drain();
    while (rays_pending.size() > 0 || s_axis_tvalid || cells_due.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_rays(int count, int top);
    int n, k;
    logic [vrt_pkg::LIM_W-1:0] lim;
    logic [vrt_pkg::CLS_W-1:0] cls;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        rays_pending.push_back(start_word(40'({$urandom, $urandom}),
                                          40'({$urandom, $urandom}),
                                          40'({$urandom, $urandom}), rand_dir(),
                                          rand_dir(), rand_dir(), 16'($urandom)));
      end else begin
        lim = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(0, 3072));
        rays_pending.push_back(start_word(near_origin(-64, 64), near_origin(-2, top + 2),
                                          near_origin(-64, 64), rand_dir(), rand_dir(),
                                          rand_dir(), lim));
      end
      n++;
      k = $urandom_range(0, 8);
      repeat (k) begin
        cls = ($urandom_range(0, 5) == 0) ? 2'($urandom) : vrt_pkg::CLS_PASS;
        rays_pending.push_back(answer_word(cls));
        n++;
      end
      if ($urandom_range(0, 3) != 0) begin
        rays_pending.push_back(answer_word(2'($urandom_range(1, 3))));
        n++;
      end
      if ($urandom_range(0, 9) == 0) begin
        rays_pending.push_back(answer_word(2'($urandom)));
        n++;
      end
    end
  endtask

  initial begin
    height = vrt_pkg::WH_RESET;
    active = 1'b0;
    {cell_x, cell_y, cell_z} = '0;
    {next_x, next_y, next_z, step_x, step_y, step_z} = '0;
    {sg_x, sg_y, sg_z} = '0;
    budget = '0;
    limit_held = '0;
    face_held = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    rays_pending.push_back(answer_word(vrt_pkg::CLS_SOLID));
    rays_pending.push_back(start_word(40'h0000050000, 40'h0000050000, 40'h0000050000,
                                      16'h0000, 16'h0000, 16'h0000, 16'h0400));
    rays_pending.push_back(start_word(40'h0000050000, 40'h0000050000, 40'h0000050000,
                                      16'h4000, 16'h0000, 16'h0000, 16'h0000));
    rays_pending.push_back(start_word(40'h0000058000, 40'h0000058000, 40'h0000058000,
                                      16'h4000, 16'h0000, 16'h0000, 16'h0800));
    repeat (3) rays_pending.push_back(answer_word(vrt_pkg::CLS_PASS));
    rays_pending.push_back(answer_word(vrt_pkg::CLS_SOLID));
    rays_pending.push_back(start_word(40'h0000018000, 40'h0000008000, 40'h0000018000,
                                      16'h0000, 16'hC000, 16'h0000, 16'h0800));
    rays_pending.push_back(start_word(40'h0000000000, 40'h0000030000, 40'h0000000000,
                                      16'h4000, 16'h4000, 16'h4000, 16'h0600));
    repeat (4) rays_pending.push_back(answer_word(vrt_pkg::CLS_PASS));
    rays_pending.push_back(start_word(40'h7FFFFFFFFF, 40'h0000108000, 40'h8000000000,
                                      16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF));
    rays_pending.push_back(answer_word(vrt_pkg::CLS_PASS));
    rays_pending.push_back(answer_word(2'd2));
    rays_pending.push_back(start_word(40'h8000000000, 40'h00000A0000, 40'h7FFFFFFFFF,
                                      16'h7FFF, 16'h8001, 16'h7FFF, 16'h0300));
    rays_pending.push_back(answer_word(2'd3));
    rays_pending.push_back(answer_word(vrt_pkg::CLS_PASS));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_height(13'd1);
        1: write_height(13'd4096);
        2: write_height(13'd0);
        3: write_height(13'h1FFF);
        4: write_height(vrt_pkg::WH_RESET);
        default: write_height(13'($urandom_range(1, 64)));
      endcase
      idle_on = (phase != 5);
      if (phase == 6) hold_req = 1'b1;
      random_rays(250, height > 64 ? 64 : int'(height));
      drain();
    end

    $display("Covered %0d input words over %0d height settings with random idling.",
             words_in, heights_used);
    $display("Checked %0d queries, %0d hits and %0d misses.",
             queries_seen, hits_seen, misses_seen);
    if (errors == 0) begin
      $display("voxel_ray_traversal_unit_test passed");
    end else begin
      $display("voxel_ray_traversal_unit_test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/vrt_pkg.sv
design/vrt_ctrl.sv
design/vrt_datapath.sv
design/voxel_ray_traversal_unit.sv
tb/voxel_ray_traversal_unit_test.sv
